FILE: rtl/psc_pkg.sv
package psc_pkg;

    localparam int MODE_W     = 2;
    localparam int DIST_W     = 19;
    localparam int IDX_W      = 3;
    localparam int OFF_W      = 16;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int FIELD_W    = 16;
    localparam int LANES      = 4;
    localparam int REM_W      = 20;

    localparam logic [MODE_W-1:0] MODE_FWD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABS = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_HI = 2'd2;

    typedef struct packed {
        logic load;
        logic prep;
        logic start;
        logic step;
    } psc_cmd_t;

    typedef struct packed {
        logic nop;
        logic done;
    } psc_stat_t;

endpackage

FILE: rtl/psc_ifs.sv
interface psc_in_if import psc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output mode, output distance, input ready);
    modport sink   (input valid, input mode, input distance, output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] segment_index;
    logic [OFF_W-1:0] segment_offset;

    modport source (output valid, output segment_index, output segment_offset, input ready);
    modport sink   (input valid, input segment_index, input segment_offset, output ready);
endinterface

interface psc_cfg_if import psc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/path_segment_cursor_top.sv
// channel | dir | payload                          | transfer when
// in_ch   | in  | mode, distance                   | in_ch.valid && in_ch.ready
// out_ch  | out | segment_index, segment_offset    | out_ch.valid && out_ch.ready
// cfg     | in  | index, data                      | cfg.valid && cfg.ready
//
// One item at a time: accept, normalize, first compare, then one segment per
// cycle until the result is found; mode 3 skips the compare and the walk.
// The segment walk reads lengths through the single length read port.
// Reset gives segment_count 1, all lengths 0, position segment 0 offset 0.
// in_ch.ready stays low until the result transfers; cfg.ready is always high.
module path_segment_cursor_top import psc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 8,
    parameter int LENGTH_BITS  = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    psc_in_if.sink   in_ch,
    psc_out_if.source out_ch,
    psc_cfg_if.sink  cfg
);

    psc_cmd_t  cmd;
    psc_stat_t stat;

    assign cfg.ready = 1'b1;

    psc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    psc_dpath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_mode        (in_ch.mode),
        .in_distance    (in_ch.distance),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .segment_index  (out_ch.segment_index),
        .segment_offset (out_ch.segment_offset)
    );

endmodule

FILE: rtl/psc_ctrl.sv
module psc_ctrl import psc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  psc_stat_t stat,
    output psc_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = stat.nop ? ST_OUT : ST_START;
            end
            ST_START, ST_WALK:
            begin
                state_next = stat.done ? ST_OUT : ST_WALK;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        cmd.load  = (state_reg == ST_IDLE) && in_valid;
        cmd.prep  = (state_reg == ST_PREP);
        cmd.start = (state_reg == ST_START);
        cmd.step  = (state_reg == ST_WALK);
    end

    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_PREP))
        else $error("accepted item did not enter prep");

    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_ready) |=> (state_reg == ST_IDLE))
        else $error("result offered again after transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_ready) |=> (state_reg == ST_OUT))
        else $error("result dropped before transfer");

endmodule

FILE: rtl/psc_dpath.sv
module psc_dpath import psc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 8,
    parameter int LENGTH_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  psc_cmd_t              cmd,
    output psc_stat_t             stat,
    input  logic [MODE_W-1:0]     in_mode,
    input  logic [DIST_W-1:0]     in_distance,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [IDX_W-1:0]      segment_index,
    output logic [OFF_W-1:0]      segment_offset
);

    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    logic [CNT_W-1:0]       count_reg;
    logic [LENGTH_BITS-1:0] len_reg [MAX_SEGMENTS];

    logic [SEG_W-1:0]       seg_reg, seg_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [MODE_W-1:0]      mode_reg;
    logic [DIST_W-1:0]      dist_reg;

    logic [CNT_W-1:0]       last_cnt;
    logic [SEG_W-1:0]       last_idx;
    logic                   stale;
    logic                   at_last;
    logic                   bwd;
    logic [SEG_W-1:0]       seg_dec;
    logic [SEG_W-1:0]       rd_idx;
    logic [LENGTH_BITS-1:0] rlen;
    logic [REM_W-1:0]       len_x;
    logic [REM_W-1:0]       off_x;
    logic [REM_W-1:0]       dist_x;
    logic [REM_W-1:0]       fwd_sum;
    logic [REM_W-1:0]       target;
    logic                   done;

    // last segment in use, with out-of-range counts folded in
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            last_cnt = '0;
        end
        else if (count_reg > CNT_W'(MAX_SEGMENTS))
        begin
            last_cnt = CNT_W'(MAX_SEGMENTS - 1);
        end
        else
        begin
            last_cnt = count_reg - CNT_W'(1);
        end
    end

    assign last_idx = last_cnt[SEG_W-1:0];
    assign stale    = (seg_reg > last_idx);
    assign at_last  = (seg_reg == last_idx);
    assign bwd      = (mode_reg == MODE_BWD);
    assign seg_dec  = seg_reg - SEG_W'(1);

    always_comb
    begin
        priority if (cmd.prep && stale)
        begin
            rd_idx = last_idx;
        end
        else if (cmd.step && bwd)
        begin
            rd_idx = seg_dec;
        end
        else
        begin
            rd_idx = seg_reg;
        end
    end

    assign rlen    = len_reg[rd_idx];
    assign len_x   = REM_W'(rlen);
    assign off_x   = REM_W'(off_reg);
    assign dist_x  = REM_W'(dist_reg);
    assign fwd_sum = off_x + dist_x;
    assign target  = cmd.start ? fwd_sum : rem_reg;

    always_comb
    begin
        seg_next = seg_reg;
        off_next = off_reg;
        rem_next = rem_reg;
        done     = 1'b0;

        if (cmd.load && in_mode == MODE_ABS)
        begin
            seg_next = '0;
            off_next = '0;
        end

        if (cmd.prep && mode_reg != MODE_NOP)
        begin
            seg_next = stale ? last_idx : seg_reg;
            off_next = (stale || off_reg > rlen) ? rlen : off_reg;
        end

        if (cmd.start && bwd)
        begin
            priority if (off_x >= dist_x)
            begin
                off_next = LENGTH_BITS'(off_x - dist_x);
                done     = 1'b1;
            end
            else if (seg_reg == '0)
            begin
                off_next = '0;
                done     = 1'b1;
            end
            else
            begin
                rem_next = dist_x - off_x;
            end
        end

        if (cmd.step && bwd)
        begin
            seg_next = seg_dec;
            if (len_x >= rem_reg)
            begin
                off_next = LENGTH_BITS'(len_x - rem_reg);
                done     = 1'b1;
            end
            else
            begin
                rem_next = rem_reg - len_x;
                if (seg_dec == '0)
                begin
                    off_next = '0;
                    done     = 1'b1;
                end
            end
        end

        if ((cmd.start || cmd.step) && !bwd)
        begin
            priority if (len_x >= target)
            begin
                off_next = LENGTH_BITS'(target);
                done     = 1'b1;
            end
            else if (at_last)
            begin
                off_next = rlen;
                done     = 1'b1;
            end
            else
            begin
                rem_next = target - len_x;
                seg_next = seg_reg + SEG_W'(1);
            end
        end
    end

    always_comb
    begin
        stat.nop  = (mode_reg == MODE_NOP);
        stat.done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            seg_reg <= seg_next;
            off_reg <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            dist_reg <= in_distance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COUNT)
            begin
                count_reg <= cfg_data[CNT_W-1:0];
            end
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                if ((i < LANES && cfg_index == REG_LEN_LO) ||
                    (i >= LANES && cfg_index == REG_LEN_HI))
                begin
                    len_reg[i] <= cfg_data[FIELD_W*(i % LANES) +: LENGTH_BITS];
                end
            end
        end
    end

    assign segment_index  = IDX_W'(seg_reg);
    assign segment_offset = OFF_W'(off_reg);

    a_abs_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && in_mode == MODE_ABS) |=> (seg_reg == '0 && off_reg == '0))
        else $error("absolute move did not restart at origin");

    a_off_in_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && done && !cfg_we) |=> (off_reg <= len_reg[seg_reg]))
        else $error("offset beyond segment length after walk");

    a_seg_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !cfg_we && seg_reg <= last_idx) |=> (seg_reg <= last_idx))
        else $error("walk left the segments in use");

endmodule
